/* hdl/upa_pkg.sv */
`timescale 1ns / 1ps

package upa_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_DIV_ZERO = 2'd1,
        STATUS_SAT      = 2'd2
    } status_t;

endpackage

/* hdl/upa_mul_cell.sv */
`timescale 1ns / 1ps

// One shift-add step per lane: fold in bit BIT of the multiplier.
module upa_mul_cell #(
    parameter int AW     = 32,
    parameter int BW     = 32,
    parameter int BIT    = 0,
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [LANES-1:0][AW-1:0]          in_a,
    input  logic [LANES-1:0][BW-1:0]          in_b,
    input  logic [LANES-1:0][AW+BW-1:0]       in_acc,
    input  logic [SIDE_W-1:0]                 in_side,
    output logic                              out_valid,
    output logic [LANES-1:0][AW-1:0]          out_a,
    output logic [LANES-1:0][BW-1:0]          out_b,
    output logic [LANES-1:0][AW+BW-1:0]       out_acc,
    output logic [SIDE_W-1:0]                 out_side
);

    logic                        valid_reg;
    logic [LANES-1:0][AW-1:0]    a_reg;
    logic [LANES-1:0][BW-1:0]    b_reg;
    logic [LANES-1:0][AW+BW-1:0] acc_reg;
    logic [LANES-1:0][AW+BW-1:0] acc_next;
    logic [SIDE_W-1:0]           side_reg;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            acc_next[l] = in_acc[l];
            if (in_b[l][BIT]) begin
                acc_next[l] = in_acc[l] + ((AW+BW)'(in_a[l]) << BIT);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg    <= in_a;
            b_reg    <= in_b;
            acc_reg  <= acc_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_a     = a_reg;
    assign out_b     = b_reg;
    assign out_acc   = acc_reg;
    assign out_side  = side_reg;

endmodule

/* hdl/upa_div_cell.sv */
`timescale 1ns / 1ps

// One restoring division step per lane: bring down numerator bit BIT.
module upa_div_cell #(
    parameter int NW     = 48,
    parameter int DW     = 32,
    parameter int BIT    = 0,
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [DW-1:0]                in_d,
    input  logic [LANES-1:0][NW-1:0]     in_n,
    input  logic [LANES-1:0][DW-1:0]     in_rem,
    input  logic [LANES-1:0][NW-1:0]     in_q,
    input  logic [SIDE_W-1:0]            in_side,
    output logic                         out_valid,
    output logic [DW-1:0]                out_d,
    output logic [LANES-1:0][NW-1:0]     out_n,
    output logic [LANES-1:0][DW-1:0]     out_rem,
    output logic [LANES-1:0][NW-1:0]     out_q,
    output logic [SIDE_W-1:0]            out_side
);

    logic                     valid_reg;
    logic [DW-1:0]            d_reg;
    logic [LANES-1:0][NW-1:0] n_reg;
    logic [LANES-1:0][DW-1:0] rem_reg;
    logic [LANES-1:0][DW-1:0] rem_next;
    logic [LANES-1:0][NW-1:0] q_reg;
    logic [LANES-1:0][NW-1:0] q_next;
    logic [SIDE_W-1:0]        side_reg;
    logic [LANES-1:0][DW:0]   trial;
    logic [LANES-1:0][DW:0]   diff;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            trial[l]  = {in_rem[l], in_n[l][BIT]};
            diff[l]   = trial[l] - {1'b0, in_d};
            q_next[l] = in_q[l];
            if (trial[l] >= {1'b0, in_d}) begin
                rem_next[l]    = diff[l][DW-1:0];
                q_next[l][BIT] = 1'b1;
            end else begin
                rem_next[l] = trial[l][DW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg    <= in_d;
            n_reg    <= in_n;
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_d     = d_reg;
    assign out_n     = n_reg;
    assign out_rem   = rem_reg;
    assign out_q     = q_reg;
    assign out_side  = side_reg;

endmodule

/* hdl/upa_sqrt_cell.sv */
`timescale 1ns / 1ps

// One digit of the integer square root: bring down two radicand bits.
module upa_sqrt_cell #(
    parameter int RW     = 32,
    parameter int STEP   = 0,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [2*RW-1:0]   in_n,
    input  logic [RW-1:0]     in_root,
    input  logic [RW+1:0]     in_rem,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [2*RW-1:0]   out_n,
    output logic [RW-1:0]     out_root,
    output logic [RW+1:0]     out_rem,
    output logic [SIDE_W-1:0] out_side
);

    localparam int HI = 2*RW - 1 - 2*STEP;

    logic              valid_reg;
    logic [2*RW-1:0]   n_reg;
    logic [RW-1:0]     root_reg;
    logic [RW-1:0]     root_next;
    logic [RW+1:0]     rem_reg;
    logic [RW+1:0]     rem_next;
    logic [SIDE_W-1:0] side_reg;
    logic [RW+3:0]     rem_sh;
    logic [RW+3:0]     trial;
    logic [RW+3:0]     diff;
    logic              ge;

    always_comb begin
        rem_sh    = {in_rem, in_n[HI -: 2]};
        trial     = {2'b00, in_root, 2'b01};
        diff      = rem_sh - trial;
        ge        = rem_sh >= trial;
        rem_next  = ge ? diff[RW+1:0] : rem_sh[RW+1:0];
        root_next = {in_root[RW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg    <= in_n;
            root_reg <= root_next;
            rem_reg  <= rem_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_n     = n_reg;
    assign out_root  = root_reg;
    assign out_rem   = rem_reg;
    assign out_side  = side_reg;

endmodule

/* hdl/uncertainty_propagation_alu_core.sv */
`timescale 1ns / 1ps

// Fixed-point arithmetic on value/uncertainty pairs: add, subtract, multiply or divide
// two signed values and return the value plus the first-order Gaussian error
// (root-sum-square of the partial terms), saturated, with a status code. The datapath
// is a row of one-bit cells: a restoring divider for the quotient and the divide error
// term, a shift-add multiplier for the products, a second divider for q*eb/vb, a
// squaring multiplier and a digit-by-digit square root. One beat is accepted every
// cycle unless the output buffer's second entry is full, which stalls the whole
// row. A two-entry output buffer lets input beats keep flowing while one result waits.
module uncertainty_propagation_alu_core #(
    parameter int DATA_WIDTH = upa_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = upa_pkg::FRAC_BITS_DEF,
    localparam int S_TDATA_W = ((4*DATA_WIDTH - 2) + 7) / 8 * 8,
    localparam int M_TDATA_W = ((2*DATA_WIDTH - 1) + 7) / 8 * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // value_a, error_a, value_b, error_b
    input  logic [S_TDATA_W-1:0] s_tdata,
    // func
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // result_value, result_error
    output logic [M_TDATA_W-1:0] m_tdata,
    // status
    output logic [1:0]           m_tuser
);

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int EW  = W - 1;
    localparam int QW  = W + F;
    localparam int NW2 = 2*W - 1;
    localparam int PW  = 2*W + F;
    localparam logic [W-1:0]  VMAX = {1'b0, {EW{1'b1}}};
    localparam logic [W-1:0]  VMIN = {1'b1, {EW{1'b0}}};
    localparam logic [EW-1:0] EMAX = {EW{1'b1}};

    typedef struct packed {
        upa_pkg::func_t func;
        logic           negq;
        logic [W-1:0]   ma;
        logic [W-1:0]   mb;
        logic [EW-1:0]  ea;
        logic [EW-1:0]  eb;
        logic [W-1:0]   as_val;
        logic           as_sat;
        logic           divz;
    } front_t;

    typedef struct packed {
        front_t        f;
        logic [W-1:0]  dval;
        logic          dsat;
        logic [W-1:0]  qmag;
        logic [EW-1:0] t1d;
        logic          t1d_big;
    } quot_t;

    typedef struct packed {
        upa_pkg::func_t func;
        logic           divz;
        logic [W-1:0]   val;
        logic           vsat;
        logic [EW-1:0]  t1;
        logic           t1big;
        logic [EW-1:0]  t2;
        logic           t2big;
    } prod_t;

    typedef struct packed {
        logic         divz;
        logic [W-1:0] val;
        logic         vsat;
        logic         big;
    } term_t;

    typedef struct packed {
        logic [W-1:0]     val;
        logic [EW-1:0]    err;
        upa_pkg::status_t status;
    } out_t;

    typedef struct packed {
        logic [W-1:0] val;
        logic [W-1:0] mag;
        logic         sat;
    } satv_t;

    localparam int FS_W = $bits(front_t);
    localparam int QS_W = $bits(quot_t);
    localparam int PS_W = $bits(prod_t);
    localparam int TS_W = $bits(term_t);

    function automatic satv_t sat_val(input logic [PW-1:0] m, input logic neg);
        satv_t         r;
        logic [PW-1:0] lim;
        lim   = neg ? PW'(VMIN) : PW'(VMAX);
        r.sat = m > lim;
        r.mag = r.sat ? lim[W-1:0] : m[W-1:0];
        r.val = neg ? (~r.mag + 1'b1) : r.mag;
        return r;
    endfunction

    logic en;

    // ---------------- front stage ----------------
    upa_pkg::func_t in_func;
    logic [W-1:0]   va, vb;
    logic [EW-1:0]  ea_in, eb_in;
    logic [W:0]     ext_a, ext_b, addend, sum_ab;
    logic           s0_valid_reg;
    front_t         s0_reg, s0_next;

    always_comb begin
        in_func = upa_pkg::func_t'(s_tuser);
        va      = s_tdata[W-1:0];
        ea_in   = s_tdata[W+EW-1:W];
        vb      = s_tdata[2*W+EW-1:W+EW];
        eb_in   = s_tdata[2*W+2*EW-1:2*W+EW];
        ext_a   = {va[W-1], va};
        ext_b   = {vb[W-1], vb};
        addend  = (in_func == upa_pkg::FUNC_SUB) ? (~ext_b + 1'b1) : ext_b;
        sum_ab  = ext_a + addend;

        s0_next.func   = in_func;
        s0_next.negq   = va[W-1] ^ vb[W-1];
        s0_next.ma     = va[W-1] ? (~va + 1'b1) : va;
        s0_next.mb     = vb[W-1] ? (~vb + 1'b1) : vb;
        s0_next.ea     = ea_in;
        s0_next.eb     = eb_in;
        s0_next.as_sat = sum_ab[W] != sum_ab[W-1];
        s0_next.as_val = s0_next.as_sat ? (sum_ab[W] ? VMIN : VMAX) : sum_ab[W-1:0];
        s0_next.divz   = (in_func == upa_pkg::FUNC_DIV) && (vb == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (en) begin
            s0_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_reg <= s0_next;
        end
    end

    // ---------------- quotient and divide error term ----------------
    logic                 d1_valid [0:QW];
    logic [W-1:0]         d1_d     [0:QW];
    logic [1:0][QW-1:0]   d1_n     [0:QW];
    logic [1:0][W-1:0]    d1_rem   [0:QW];
    logic [1:0][QW-1:0]   d1_q     [0:QW];
    logic [FS_W-1:0]      d1_side  [0:QW];

    assign d1_valid[0] = s0_valid_reg;
    assign d1_d[0]     = s0_reg.mb;
    assign d1_n[0][0]  = {s0_reg.ma, {F{1'b0}}};
    assign d1_n[0][1]  = {1'b0, s0_reg.ea, {F{1'b0}}};
    assign d1_rem[0]   = '0;
    assign d1_q[0]     = '0;
    assign d1_side[0]  = s0_reg;

    for (genvar i = 0; i < QW; i++) begin : g_div1
        upa_div_cell #(
            .NW(QW), .DW(W), .BIT(QW-1-i), .LANES(2), .SIDE_W(FS_W)
        ) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_valid(d1_valid[i]), .in_d(d1_d[i]), .in_n(d1_n[i]),
            .in_rem(d1_rem[i]), .in_q(d1_q[i]), .in_side(d1_side[i]),
            .out_valid(d1_valid[i+1]), .out_d(d1_d[i+1]), .out_n(d1_n[i+1]),
            .out_rem(d1_rem[i+1]), .out_q(d1_q[i+1]), .out_side(d1_side[i+1])
        );
    end

    front_t d1_f;
    satv_t  qsat;
    logic   q_valid_reg;
    quot_t  q_reg, q_next;

    always_comb begin
        d1_f           = front_t'(d1_side[QW]);
        qsat           = sat_val(PW'(d1_q[QW][0]), d1_f.negq);
        q_next.f       = d1_f;
        q_next.dval    = qsat.val;
        q_next.dsat    = qsat.sat;
        q_next.qmag    = qsat.mag;
        q_next.t1d     = d1_q[QW][1][EW-1:0];
        q_next.t1d_big = |d1_q[QW][1][QW-1:EW];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid_reg <= 1'b0;
        end else if (en) begin
            q_valid_reg <= d1_valid[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

    // ---------------- products ----------------
    logic                 mc_valid [0:W];
    logic [2:0][W-1:0]    mc_a     [0:W];
    logic [2:0][W-1:0]    mc_b     [0:W];
    logic [2:0][2*W-1:0]  mc_acc   [0:W];
    logic [QS_W-1:0]      mc_side  [0:W];

    assign mc_valid[0] = q_valid_reg;
    assign mc_a[0][0]  = q_reg.f.ma;
    assign mc_b[0][0]  = q_reg.f.mb;
    assign mc_a[0][1]  = {1'b0, q_reg.f.ea};
    assign mc_b[0][1]  = q_reg.f.mb;
    // divide reuses this lane for the saturated quotient times eb
    assign mc_a[0][2]  = (q_reg.f.func == upa_pkg::FUNC_DIV) ? q_reg.qmag : q_reg.f.ma;
    assign mc_b[0][2]  = {1'b0, q_reg.f.eb};
    assign mc_acc[0]   = '0;
    assign mc_side[0]  = q_reg;

    for (genvar i = 0; i < W; i++) begin : g_mul
        upa_mul_cell #(
            .AW(W), .BW(W), .BIT(i), .LANES(3), .SIDE_W(QS_W)
        ) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_valid(mc_valid[i]), .in_a(mc_a[i]), .in_b(mc_b[i]),
            .in_acc(mc_acc[i]), .in_side(mc_side[i]),
            .out_valid(mc_valid[i+1]), .out_a(mc_a[i+1]), .out_b(mc_b[i+1]),
            .out_acc(mc_acc[i+1]), .out_side(mc_side[i+1])
        );
    end

    quot_t          mc_q;
    satv_t          psat;
    logic           p_valid_reg;
    prod_t          p_reg, p_next;
    logic [W-1:0]   p_mb_reg;
    logic [NW2-1:0] p_num_reg;

    always_comb begin
        mc_q         = quot_t'(mc_side[W]);
        psat         = sat_val(PW'(mc_acc[W][0][2*W-1:F]), mc_q.f.negq);
        p_next.func  = mc_q.f.func;
        p_next.divz  = mc_q.f.divz;
        p_next.val   = mc_q.f.as_val;
        p_next.vsat  = mc_q.f.as_sat;
        p_next.t1    = mc_q.f.ea;
        p_next.t1big = 1'b0;
        p_next.t2    = mc_q.f.eb;
        p_next.t2big = 1'b0;
        case (mc_q.f.func)
            upa_pkg::FUNC_ADD, upa_pkg::FUNC_SUB: begin
            end
            upa_pkg::FUNC_MUL: begin
                p_next.val   = psat.val;
                p_next.vsat  = psat.sat;
                p_next.t1    = mc_acc[W][1][EW+F-1:F];
                p_next.t1big = |mc_acc[W][1][2*W-1:EW+F];
                p_next.t2    = mc_acc[W][2][EW+F-1:F];
                p_next.t2big = |mc_acc[W][2][2*W-1:EW+F];
            end
            upa_pkg::FUNC_DIV: begin
                p_next.val   = mc_q.dval;
                p_next.vsat  = mc_q.dsat;
                p_next.t1    = mc_q.t1d;
                p_next.t1big = mc_q.t1d_big;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (en) begin
            p_valid_reg <= mc_valid[W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg     <= p_next;
            p_mb_reg  <= mc_q.f.mb;
            p_num_reg <= mc_acc[W][2][NW2-1:0];
        end
    end

    // ---------------- q*eb/vb ----------------
    logic                 d2_valid [0:NW2];
    logic [W-1:0]         d2_d     [0:NW2];
    logic [0:0][NW2-1:0]  d2_n     [0:NW2];
    logic [0:0][W-1:0]    d2_rem   [0:NW2];
    logic [0:0][NW2-1:0]  d2_q     [0:NW2];
    logic [PS_W-1:0]      d2_side  [0:NW2];

    assign d2_valid[0] = p_valid_reg;
    assign d2_d[0]     = p_mb_reg;
    assign d2_n[0][0]  = p_num_reg;
    assign d2_rem[0]   = '0;
    assign d2_q[0]     = '0;
    assign d2_side[0]  = p_reg;

    for (genvar i = 0; i < NW2; i++) begin : g_div2
        upa_div_cell #(
            .NW(NW2), .DW(W), .BIT(NW2-1-i), .LANES(1), .SIDE_W(PS_W)
        ) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_valid(d2_valid[i]), .in_d(d2_d[i]), .in_n(d2_n[i]),
            .in_rem(d2_rem[i]), .in_q(d2_q[i]), .in_side(d2_side[i]),
            .out_valid(d2_valid[i+1]), .out_d(d2_d[i+1]), .out_n(d2_n[i+1]),
            .out_rem(d2_rem[i+1]), .out_q(d2_q[i+1]), .out_side(d2_side[i+1])
        );
    end

    prod_t         d2_p;
    logic [EW-1:0] t2_sel;
    logic          t2big_sel;
    logic          t_valid_reg;
    term_t         t_reg, t_next;
    logic [EW-1:0] t1_reg, t2_reg;

    always_comb begin
        d2_p      = prod_t'(d2_side[NW2]);
        t2_sel    = d2_p.t2;
        t2big_sel = d2_p.t2big;
        if (d2_p.func == upa_pkg::FUNC_DIV) begin
            t2_sel    = d2_q[NW2][0][EW-1:0];
            t2big_sel = |d2_q[NW2][0][NW2-1:EW];
        end
        t_next.divz = d2_p.divz;
        t_next.val  = d2_p.val;
        t_next.vsat = d2_p.vsat;
        t_next.big  = d2_p.t1big | t2big_sel;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_valid_reg <= 1'b0;
        end else if (en) begin
            t_valid_reg <= d2_valid[NW2];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg  <= t_next;
            t1_reg <= d2_p.t1;
            t2_reg <= t2_sel;
        end
    end

    // ---------------- squares ----------------
    logic                  sq_valid [0:EW];
    logic [1:0][EW-1:0]    sq_a     [0:EW];
    logic [1:0][EW-1:0]    sq_b     [0:EW];
    logic [1:0][2*EW-1:0]  sq_acc   [0:EW];
    logic [TS_W-1:0]       sq_side  [0:EW];

    assign sq_valid[0] = t_valid_reg;
    assign sq_a[0][0]  = t1_reg;
    assign sq_b[0][0]  = t1_reg;
    assign sq_a[0][1]  = t2_reg;
    assign sq_b[0][1]  = t2_reg;
    assign sq_acc[0]   = '0;
    assign sq_side[0]  = t_reg;

    for (genvar i = 0; i < EW; i++) begin : g_sqr
        upa_mul_cell #(
            .AW(EW), .BW(EW), .BIT(i), .LANES(2), .SIDE_W(TS_W)
        ) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_valid(sq_valid[i]), .in_a(sq_a[i]), .in_b(sq_b[i]),
            .in_acc(sq_acc[i]), .in_side(sq_side[i]),
            .out_valid(sq_valid[i+1]), .out_a(sq_a[i+1]), .out_b(sq_b[i+1]),
            .out_acc(sq_acc[i+1]), .out_side(sq_side[i+1])
        );
    end

    logic           u_valid_reg;
    logic [NW2-1:0] u_sum_reg;
    logic [TS_W-1:0] u_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_valid_reg <= 1'b0;
        end else if (en) begin
            u_valid_reg <= sq_valid[EW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u_sum_reg  <= {1'b0, sq_acc[EW][0]} + {1'b0, sq_acc[EW][1]};
            u_side_reg <= sq_side[EW];
        end
    end

    // ---------------- square root ----------------
    logic              sr_valid [0:W];
    logic [2*W-1:0]    sr_n     [0:W];
    logic [W-1:0]      sr_root  [0:W];
    logic [W+1:0]      sr_rem   [0:W];
    logic [TS_W-1:0]   sr_side  [0:W];

    assign sr_valid[0] = u_valid_reg;
    assign sr_n[0]     = {1'b0, u_sum_reg};
    assign sr_root[0]  = '0;
    assign sr_rem[0]   = '0;
    assign sr_side[0]  = u_side_reg;

    for (genvar i = 0; i < W; i++) begin : g_sqrt
        upa_sqrt_cell #(
            .RW(W), .STEP(i), .SIDE_W(TS_W)
        ) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_valid(sr_valid[i]), .in_n(sr_n[i]), .in_root(sr_root[i]),
            .in_rem(sr_rem[i]), .in_side(sr_side[i]),
            .out_valid(sr_valid[i+1]), .out_n(sr_n[i+1]), .out_root(sr_root[i+1]),
            .out_rem(sr_rem[i+1]), .out_side(sr_side[i+1])
        );
    end

    term_t sr_t;
    logic  esat;
    out_t  fin;

    always_comb begin
        sr_t = term_t'(sr_side[W]);
        esat = sr_t.big | sr_root[W][W-1];
        if (sr_t.divz) begin
            fin.val    = '0;
            fin.err    = '0;
            fin.status = upa_pkg::STATUS_DIV_ZERO;
        end else begin
            fin.val    = sr_t.val;
            fin.err    = esat ? EMAX : sr_root[W][EW-1:0];
            fin.status = (sr_t.vsat | esat) ? upa_pkg::STATUS_SAT : upa_pkg::STATUS_OK;
        end
    end

    // ---------------- output buffer ----------------
    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    out_t out_data_reg, out_data_next;
    out_t skid_data_reg, skid_data_next;
    logic take, push;

    assign en   = !skid_valid_reg;
    assign take = out_valid_reg && m_tready;
    assign push = en && sr_valid[W];

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (take) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || take) begin
                out_valid_next = 1'b1;
                out_data_next  = fin;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = fin;
            end
        end else if (take) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_data_reg.err, out_data_reg.val});
    assign m_tuser  = out_data_reg.status;

    // ---------------- assertions ----------------
    a_skid_needs_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a main entry");

    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("skid entry dropped without a beat taken");

    a_divz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg.status == upa_pkg::STATUS_DIV_ZERO)
        |-> (out_data_reg.val == '0 && out_data_reg.err == '0))
        else $error("division by zero result not cleared");

endmodule
